FILE: rtl/gpf_pkg.sv
// Package with shared constants for the 3x3 grid peak finder.
`default_nettype none
package gpf_pkg;
    localparam int MAX_SIDE_DEF = 1024;
    localparam int VALUE_W_DEF  = 16;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam logic [APB_ADDR_W-1:0] REG_GRID_SIDE = 3'd0;
endpackage
`default_nettype wire

FILE: rtl/grid_peak_finder_3x3.sv
// Streaming 3x3 strict local-maximum detector with a line memory and an APB register.
`default_nettype none
// The block takes one word of a square grid per cycle in raster order and reports every interior
// cell that is strictly greater than its eight neighbours, with its row, column and running number
// within the grid. A new word is taken every cycle while the result side keeps up; a result is
// registered once the word that completes its window has passed the registered read of the
// line memory and the compare stage. Writing grid_side restarts the frame.
module grid_peak_finder_3x3 #(
    parameter int MAX_SIDE = gpf_pkg::MAX_SIDE_DEF,
    parameter int VALUE_W  = gpf_pkg::VALUE_W_DEF,
    localparam int AW      = $clog2(MAX_SIDE),
    localparam int SIDE_W  = AW + 1,
    localparam int PEAK_W  = 2 * AW - 2
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [gpf_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire  [gpf_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [gpf_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  wire                                 i_cell_valid,
    output logic                                o_cell_stall,
    input  wire  signed [VALUE_W-1:0]           i_cell_value,
    output logic                                o_peak_valid,
    input  wire                                 i_peak_stall,
    output logic signed [VALUE_W-1:0]           o_peak_value,
    output logic [AW-1:0]                       o_peak_row,
    output logic [AW-1:0]                       o_peak_col,
    output logic [PEAK_W-1:0]                   o_peak_number
);
    import gpf_pkg::*;

    logic [2*VALUE_W-1:0] mem [MAX_SIDE];

    logic [SIDE_W-1:0] r_grid_side;
    logic [AW-1:0]     r_side_last, n_side_last;
    logic [AW-1:0]     r_col, r_row;
    logic [PEAK_W-1:0] r_peak, n_peak;

    logic                      r_s1_valid, r_s1_test, r_s1_last;
    logic signed [VALUE_W-1:0] r_s1_value;
    logic [AW-1:0]             r_s1_addr, r_s1_row, r_s1_col;

    logic [2*VALUE_W-1:0] r_rdata, r_fwd_data, rd_eff, n_wdata;
    logic                 r_fwd;
    logic signed [VALUE_W-1:0] rd_up, rd_mid;
    logic signed [VALUE_W-1:0] r_win [9];

    logic r_out_valid;
    logic cfg_wr, cell_acc, s1_adv, s1_peak, col_end, row_end;

    assign pready = 1'b1;
    assign prdata = {{(APB_DATA_W-SIDE_W){1'b0}}, r_grid_side};
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_GRID_SIDE);

    always_comb begin
        if (pwdata[SIDE_W-1:0] == '0) begin
            n_side_last = '0;
        end else if (pwdata[SIDE_W-1:0] > SIDE_W'(MAX_SIDE)) begin
            n_side_last = AW'(MAX_SIDE - 1);
        end else begin
            n_side_last = AW'(pwdata[SIDE_W-1:0] - SIDE_W'(1));
        end
    end

    assign rd_eff  = r_fwd ? r_fwd_data : r_rdata;
    assign rd_up   = rd_eff[2*VALUE_W-1:VALUE_W];
    assign rd_mid  = rd_eff[VALUE_W-1:0];
    assign n_wdata = {rd_mid, r_s1_value};

    always_comb begin
        s1_peak = r_s1_test
            && (r_win[5] > r_win[1]) && (r_win[5] > r_win[2]) && (r_win[5] > rd_up)
            && (r_win[5] > r_win[4]) && (r_win[5] > rd_mid)
            && (r_win[5] > r_win[7]) && (r_win[5] > r_win[8]) && (r_win[5] > r_s1_value);
    end

    assign n_peak       = r_peak + PEAK_W'(1);
    assign s1_adv       = r_s1_valid && (!s1_peak || !r_out_valid || !i_peak_stall);
    assign o_cell_stall = r_s1_valid && !s1_adv;
    assign cell_acc     = i_cell_valid && !o_cell_stall;
    assign col_end      = (r_col == r_side_last);
    assign row_end      = (r_row == r_side_last);
    assign o_peak_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            mem[r_s1_addr] <= n_wdata;
        end
        if (cell_acc) begin
            r_rdata    <= mem[r_col];
            r_fwd      <= s1_adv && (r_s1_addr == r_col);
            r_fwd_data <= n_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side <= SIDE_W'(MAX_SIDE);
            r_side_last <= AW'(MAX_SIDE - 1);
            r_col       <= '0;
            r_row       <= '0;
            r_peak      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                r_grid_side <= pwdata[SIDE_W-1:0];
                r_side_last <= n_side_last;
                r_col       <= '0;
                r_row       <= '0;
            end else if (cell_acc) begin
                if (col_end) begin
                    r_col <= '0;
                    r_row <= row_end ? '0 : r_row + AW'(1);
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end

            if (cell_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (cfg_wr) begin
                r_peak <= '0;
            end else if (s1_adv) begin
                if (r_s1_last) begin
                    r_peak <= '0;
                end else if (s1_peak) begin
                    r_peak <= n_peak;
                end
            end

            if (s1_adv) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k*3]   <= r_win[k*3+1];
                    r_win[k*3+1] <= r_win[k*3+2];
                end
                r_win[2] <= rd_up;
                r_win[5] <= rd_mid;
                r_win[8] <= r_s1_value;
            end

            if (s1_adv && s1_peak) begin
                r_out_valid <= 1'b1;
            end else if (!i_peak_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_acc) begin
            r_s1_value <= i_cell_value;
            r_s1_addr  <= r_col;
            r_s1_row   <= r_row - AW'(1);
            r_s1_col   <= r_col - AW'(1);
            r_s1_test  <= (r_row >= AW'(2)) && (r_col >= AW'(2));
            r_s1_last  <= col_end && row_end;
        end
        if (s1_adv && s1_peak) begin
            o_peak_value  <= r_win[5];
            o_peak_row    <= r_s1_row;
            o_peak_col    <= r_s1_col;
            o_peak_number <= n_peak;
        end
    end

    a_stall_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cell_stall |-> r_s1_valid)
        else $error("Input stalled with an empty compare stage.");

    a_peak_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_peak_valid |-> (o_peak_row != '0) && (o_peak_col != '0))
        else $error("Peak reported on the grid border.");

    a_peak_number_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_peak_valid |-> (o_peak_number != '0))
        else $error("Peak reported with a zero ordinal.");

    a_peak_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && s1_peak) |=> r_out_valid)
        else $error("Detected peak did not reach the result register.");
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the 3x3 grid peak finder: directed and random grids checked against a predictor.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW   = gpf_pkg::VALUE_W_DEF;
    localparam int MAXS = gpf_pkg::MAX_SIDE_DEF;
    localparam int AW   = $clog2(MAXS);
    localparam int PW   = 2 * AW - 2;
    localparam logic signed [VW-1:0] MIN_V = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] MAX_V = {1'b0, {(VW-1){1'b1}}};

    typedef enum {SPREAD_FULL, SPREAD_TIES, SPREAD_EXTREME, SPREAD_MIXED} t_value_spread;

    typedef struct packed {
        logic signed [VW-1:0] value;
        logic [AW-1:0]        row;
        logic [AW-1:0]        col;
        logic [PW-1:0]        number;
    } t_peak;

    class t_peak_tracker;
        logic signed [VW-1:0] upper_line [MAXS];
        logic signed [VW-1:0] middle_line [MAXS];
        logic signed [VW-1:0] win [3][3];
        int unsigned row_cnt;
        int unsigned col_cnt;
        int unsigned peak_cnt;
        int unsigned side_reg;
        t_peak       peaks_due [$];
        int          errors;

        function new();
            foreach (upper_line[i]) upper_line[i] = '0;
            foreach (middle_line[i]) middle_line[i] = '0;
            foreach (win[i, j]) win[i][j] = '0;
            row_cnt  = 0;
            col_cnt  = 0;
            peak_cnt = 0;
            side_reg = MAXS;
            errors   = 0;
        endfunction

        function void restart_grid(int unsigned side);
            side_reg = side & 'h7FF;
            row_cnt  = 0;
            col_cnt  = 0;
            peak_cnt = 0;
        endfunction

        function int outstanding();
            return peaks_due.size();
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void take_cell(logic signed [VW-1:0] v);
            int unsigned          eff;
            int unsigned          c;
            int unsigned          r;
            int unsigned          idx;
            logic signed [VW-1:0] up;
            logic signed [VW-1:0] mid;
            logic signed [VW-1:0] centre;
            bit                   is_peak;
            t_peak                p;
            if (side_reg == 0) eff = 1;
            else if (side_reg > MAXS) eff = MAXS;
            else eff = side_reg;
            c   = col_cnt;
            r   = row_cnt;
            idx = c % MAXS;
            up  = upper_line[idx];
            mid = middle_line[idx];
            for (int k = 0; k < 3; k++) begin
                win[k][0] = win[k][1];
                win[k][1] = win[k][2];
            end
            win[0][2] = up;
            win[1][2] = mid;
            win[2][2] = v;
            upper_line[idx]  = mid;
            middle_line[idx] = v;
            if (r >= 2 && c >= 2) begin
                centre  = win[1][1];
                is_peak = 1'b1;
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        if (!(i == 1 && j == 1) && !(centre > win[i][j])) is_peak = 1'b0;
                if (is_peak) begin
                    peak_cnt = (peak_cnt + 1) % (1 << PW);
                    p.value  = centre;
                    p.row    = AW'(r - 1);
                    p.col    = AW'(c - 1);
                    p.number = PW'(peak_cnt);
                    peaks_due.push_back(p);
                end
            end
            col_cnt = c + 1;
            if (col_cnt >= eff) begin
                col_cnt = 0;
                row_cnt = r + 1;
                if (row_cnt >= eff) begin
                    row_cnt  = 0;
                    peak_cnt = 0;
                end
            end
        endfunction

        task check_peak(logic signed [VW-1:0] value, logic [AW-1:0] row, logic [AW-1:0] col,
                        logic [PW-1:0] number);
            t_peak want;
            if (peaks_due.size() == 0) begin
                report_mismatch($sformatf("unexpected peak %0d at row %0d col %0d number %0d",
                                          value, row, col, number));
                return;
            end
            want = peaks_due.pop_front();
            if (value !== want.value)
                report_mismatch($sformatf("peak value %0d, wanted %0d", value, want.value));
            if (row !== want.row)
                report_mismatch($sformatf("peak row %0d, wanted %0d", row, want.row));
            if (col !== want.col)
                report_mismatch($sformatf("peak column %0d, wanted %0d", col, want.col));
            if (number !== want.number)
                report_mismatch($sformatf("peak number %0d, wanted %0d", number, want.number));
        endtask
    endclass

    logic                            clk;
    logic                            rst_n      = 1'b0;
    logic                            psel       = 1'b0;
    logic                            penable    = 1'b0;
    logic                            pwrite     = 1'b0;
    logic [gpf_pkg::APB_ADDR_W-1:0]  paddr      = '0;
    logic [gpf_pkg::APB_DATA_W-1:0]  pwdata     = '0;
    logic [gpf_pkg::APB_DATA_W-1:0]  prdata;
    logic                            pready;
    logic                            cell_valid = 1'b0;
    logic                            cell_stall;
    logic signed [VW-1:0]            cell_value = '0;
    logic                            peak_valid;
    logic                            peak_stall = 1'b0;
    logic signed [VW-1:0]            peak_value;
    logic [AW-1:0]                   peak_row;
    logic [AW-1:0]                   peak_col;
    logic [PW-1:0]                   peak_number;

    t_peak_tracker peaks        = new();
    int            idle_pct     = 33;
    bit            hold_off_req = 1'b0;
    int unsigned   cells_sent   = 0;

    grid_peak_finder_3x3 DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_cell_valid  (cell_valid),
        .o_cell_stall  (cell_stall),
        .i_cell_value  (cell_value),
        .o_peak_valid  (peak_valid),
        .i_peak_stall  (peak_stall),
        .o_peak_value  (peak_value),
        .o_peak_row    (peak_row),
        .o_peak_col    (peak_col),
        .o_peak_number (peak_number)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // The receiver honours one long hold-off on request, otherwise it stalls at random.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                peak_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end
            peak_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && peak_valid && !peak_stall)
            peaks.check_peak(peak_value, peak_row, peak_col, peak_number);
    end

    function automatic logic signed [VW-1:0] pick_value(t_value_spread spread);
        case (spread)
            SPREAD_TIES: return VW'($urandom_range(3)) - VW'(1);
            SPREAD_EXTREME: begin
                case ($urandom_range(3))
                    0: return MIN_V;
                    1: return MAX_V;
                    2: return MIN_V + VW'(1);
                    default: return MAX_V - VW'(1);
                endcase
            end
            SPREAD_MIXED: begin
                if ($urandom_range(3) == 0) return $urandom_range(1) ? MIN_V : MAX_V;
                return VW'($urandom);
            end
            default: return VW'($urandom);
        endcase
    endfunction

    task automatic write_side(int unsigned side);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= gpf_pkg::REG_GRID_SIDE;
        pwdata  <= gpf_pkg::APB_DATA_W'(side);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        peaks.restart_grid(side);
    endtask

    task automatic push_cell(logic signed [VW-1:0] v);
        while ($urandom_range(99) < idle_pct) begin
            cell_valid <= 1'b0;
            @(posedge clk);
        end
        cell_valid <= 1'b1;
        cell_value <= v;
        @(posedge clk);
        while (cell_stall) @(posedge clk);
        peaks.take_cell(v);
        cells_sent++;
    endtask

    // A word that completes no window leaves nothing to wait for, so the task still waits after the drain.
    task automatic settle();
        while (peaks.outstanding() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_grid(int unsigned side, int unsigned n, t_value_spread spread, bit no_idle,
                            int unsigned hold_at);
        idle_pct = no_idle ? 0 : 33;
        write_side(side);
        for (int unsigned i = 0; i < n; i++) begin
            if (hold_at != 0 && i == hold_at) hold_off_req = 1'b1;
            push_cell(pick_value(spread));
        end
        cell_valid <= 1'b0;
        settle();
        idle_pct = 33;
    endtask

    initial begin
        int unsigned   side;
        int unsigned   n;
        int unsigned   k;
        t_value_spread spread;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Three grids of side three back to back, so the counters must wrap between them.
        write_side(3);
        for (int i = 0; i < 9; i++) push_cell(i == 4 ? MAX_V : MIN_V);
        for (int i = 0; i < 9; i++) push_cell(i == 4 ? MIN_V + VW'(1) : MIN_V);
        for (int i = 0; i < 9; i++) push_cell(i == 4 || i == 6 ? VW'(100) : VW'(99 - i));
        cell_valid <= 1'b0;
        settle();

        run_grid(24, 500, SPREAD_FULL, 1'b1, 0);
        run_grid(16, 512, SPREAD_FULL, 1'b0, 10);
        run_grid(1, 12, SPREAD_FULL, 1'b0, 0);
        run_grid(2, 16, SPREAD_MIXED, 1'b0, 0);
        run_grid(0, 10, SPREAD_FULL, 1'b0, 0);
        run_grid(1024, 30, SPREAD_FULL, 1'b0, 0);

        while (cells_sent < 1550) begin
            k    = $urandom_range(99);
            side = (k < 25) ? $urandom_range(40, 13) : $urandom_range(12, 3);
            n    = $urandom_range(2, 1) * side * side;
            if ($urandom_range(3) == 0) n += $urandom_range(side * side - 1);
            if (n > 400) n = 400;
            if (n > 1550 - cells_sent) n = 1550 - cells_sent;
            k = $urandom_range(9);
            if (k < 5) spread = SPREAD_FULL;
            else if (k < 7) spread = SPREAD_TIES;
            else if (k < 8) spread = SPREAD_EXTREME;
            else spread = SPREAD_MIXED;
            run_grid(side, n, spread, 1'b0, 0);
        end

        repeat (20) @(posedge clk);
        if (peaks.outstanding() != 0)
            peaks.report_mismatch($sformatf("%0d peaks never reported", peaks.outstanding()));
        if (peaks.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire
